FILE: rtl/epve_pkg.sv
package epve_pkg;

  // Counter width of the encoder; only these low bits of a sample are used
  localparam int unsigned COUNT_WIDTH = 16;
  localparam logic [15:0] CountMask =
      (COUNT_WIDTH >= 16) ? 16'hFFFF : 16'((32'd1 << COUNT_WIDTH) - 32'd1);

  localparam int unsigned POS_W    = 40;
  localparam int unsigned VEL_W    = 32;
  localparam int unsigned CHANGE_W = 42;
  localparam int unsigned VPROD_W  = 59;
  localparam int unsigned NUM_W    = 40;
  localparam int unsigned DIV_STEPS = NUM_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [1:0] REG_COUNT_TOP      = 2'd0;
  localparam logic [1:0] REG_RAD_PER_COUNT  = 2'd1;
  localparam logic [1:0] REG_SAMPLE_RATE_HZ = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic latch_in;
    logic calc;
    logic mul;
    logic div_step;
    logic fin;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic moved;
  } dp_status_t;

endpackage

FILE: rtl/epve_ctrl.sv
module epve_ctrl import epve_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [DIV_CNT_W-1:0] DivLast = DIV_CNT_W'(DIV_STEPS - 1);

  state_e               state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    in_stall_o  = (state_q != ST_IDLE);
    // drop the held result once it is transferred
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        cnt_d     = '0;
        state_d   = status_i.moved ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DivLast) state_d = ST_FIN;
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/epve_dp.sv
module epve_dp import epve_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  logic [23:0]             cfg_wdata_i,
  input  logic [15:0]             count_sample_i,
  input  logic                    zero_position_i,
  input  dp_cmd_t                 cmd_i,
  output dp_status_t              status_o,
  output logic signed [POS_W-1:0] position_o,
  output logic signed [VEL_W-1:0] velocity_o,
  output logic                    moved_o
);

  logic [15:0] count_top_q;
  logic [23:0] rad_per_count_q;
  logic [15:0] sample_rate_q;

  logic [15:0]             now_q;
  logic                    zero_q;
  logic [15:0]             prev_q;
  logic [POS_W-1:0]        acc_q;
  logic [15:0]             idle_q;
  logic                    dir_neg_q;
  logic                    moved_q;
  logic signed [CHANGE_W-1:0] change_q;
  logic [NUM_W-1:0]        num_q;
  logic signed [VPROD_W-1:0] vprod_q;
  logic [15:0]             rem_q;
  logic [NUM_W-1:0]        quo_q;
  logic signed [VEL_W-1:0] vel_q;
  logic signed [POS_W-1:0] pos_out_q;
  logic signed [VEL_W-1:0] vel_out_q;
  logic                    moved_out_q;

  // wrap-corrected count change
  logic signed [17:0] diff, span, half, delta_c;
  logic signed [24:0] rpc_s;
  logic signed [16:0] sr_s;
  logic signed [CHANGE_W-1:0] change_c;
  logic [NUM_W-1:0]   num_c;
  logic               moved_c;

  always_comb begin
    diff = $signed({2'b00, now_q}) - $signed({2'b00, prev_q});
    span = $signed({1'b0, 17'({1'b0, count_top_q} + 17'd1)});
    half = span >>> 1;
    if (diff < -half) begin
      delta_c = diff + span;
    end else if (diff > half) begin
      delta_c = diff - span;
    end else begin
      delta_c = diff;
    end
    rpc_s    = $signed({1'b0, rad_per_count_q});
    sr_s     = $signed({1'b0, sample_rate_q});
    change_c = delta_c * rpc_s;
    num_c    = {16'd0, rad_per_count_q} * {24'd0, sample_rate_q};
    moved_c  = (now_q != prev_q);
  end

  // restoring divider step: quotient of num by idle ticks
  logic [16:0] trial;
  logic        fits;
  always_comb begin
    trial = {rem_q, quo_q[NUM_W-1]};
    fits  = (trial >= {1'b0, idle_q});
  end

  // velocity with rounding and saturation
  logic signed [VPROD_W-1:0] rsum, rshift;
  logic [NUM_W:0]            mag_sum;
  logic [32:0]               mag;
  logic signed [VEL_W-1:0]   vel_move, vel_stop;
  always_comb begin
    rsum   = vprod_q + VPROD_W'(128);
    rshift = rsum >>> 8;
    if (rshift > VPROD_W'(64'sd2147483647)) begin
      vel_move = 32'sh7FFF_FFFF;
    end else if (rshift < -VPROD_W'(64'sd2147483648)) begin
      vel_move = 32'sh8000_0000;
    end else begin
      vel_move = rshift[VEL_W-1:0];
    end
    mag_sum = {1'b0, quo_q} + (NUM_W + 1)'(128);
    mag     = mag_sum[NUM_W:8];
    if (dir_neg_q) begin
      if (mag > 33'h0_8000_0000) vel_stop = 32'sh8000_0000;
      else vel_stop = 32'(~mag + 33'd1);
    end else begin
      if (mag > 33'h0_7FFF_FFFF) vel_stop = 32'sh7FFF_FFFF;
      else vel_stop = mag[VEL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_top_q     <= 16'd65535;
      rad_per_count_q <= 24'd25736;
      sample_rate_q   <= 16'd1000;
      prev_q          <= '0;
      acc_q           <= '0;
      idle_q          <= '0;
      dir_neg_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_COUNT_TOP:      count_top_q     <= cfg_wdata_i[15:0];
          REG_RAD_PER_COUNT:  rad_per_count_q <= cfg_wdata_i;
          REG_SAMPLE_RATE_HZ: sample_rate_q   <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      if (cmd_i.calc) begin
        prev_q <= now_q;
        if (moved_c) begin
          idle_q <= '0;
          if (delta_c < 0) dir_neg_q <= 1'b1;
          else if (delta_c > 0) dir_neg_q <= 1'b0;
        end else if (idle_q != 16'hFFFF) begin
          idle_q <= idle_q + 16'd1;
        end
      end
      if (cmd_i.mul) begin
        acc_q <= (zero_q ? '0 : acc_q) + change_q[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      now_q  <= count_sample_i & CountMask;
      zero_q <= zero_position_i;
    end
    if (cmd_i.calc) begin
      change_q <= change_c;
      num_q    <= num_c;
      moved_q  <= moved_c;
    end
    if (cmd_i.mul) begin
      vprod_q <= change_q * sr_s;
      rem_q   <= '0;
      quo_q   <= num_q;
    end
    if (cmd_i.div_step) begin
      if (fits) begin
        rem_q <= 16'(trial - {1'b0, idle_q});
        quo_q <= {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_q <= trial[15:0];
        quo_q <= {quo_q[NUM_W-2:0], 1'b0};
      end
    end
    if (cmd_i.fin) begin
      vel_q <= moved_q ? vel_move : vel_stop;
    end
    if (cmd_i.load_out) begin
      pos_out_q   <= $signed(acc_q);
      vel_out_q   <= vel_q;
      moved_out_q <= moved_q;
    end
  end

  assign status_o.moved = moved_q;
  assign position_o     = pos_out_q;
  assign velocity_o     = vel_out_q;
  assign moved_o        = moved_out_q;

endmodule

FILE: rtl/encoder_position_velocity_estimator_core.sv
// A sample is latched in IDLE and passes CALC, MUL, FIN and DONE when the
// count moved; when it did not, the 40-step restoring divider for 1/idle
// time runs in DIV between MUL and FIN. The next sample is taken once DONE has
// loaded the output register, while that result still waits there.
// Reset (async, active low): position, idle count, direction and previous
// count clear, registers take their defaults, and the output is empty.
module encoder_position_velocity_estimator_core import epve_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  logic [23:0]             cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [15:0]             count_sample_i,
  input  logic                    zero_position_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [POS_W-1:0] position_o,
  output logic signed [VEL_W-1:0] velocity_o,
  output logic                    moved_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  epve_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  epve_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .count_sample_i  (count_sample_i),
    .zero_position_i (zero_position_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .position_o      (position_o),
    .velocity_o      (velocity_o),
    .moved_o         (moved_o)
  );

endmodule

FILE: rtl/epve_checker.sv
module epve_checker import epve_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [POS_W-1:0] position_o,
  input logic signed [VEL_W-1:0] velocity_o,
  input logic                    moved_o
);

  logic in_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(position_o) && $stable(velocity_o) && $stable(moved_o))
    else $error("stalled result changed");

  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o)
    else $error("second sample taken while busy");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !$rose(out_valid_o))
    else $error("result appeared before any computation");

endmodule

bind encoder_position_velocity_estimator_core epve_checker u_epve_checker (.*);
